@@ src/stid_pkg.sv @@
// Shared types and codes for the sorted table insert and delete block.
package stid_pkg;

    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int FIELD_W     = 5;
    localparam int OUT_TDATA_W = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INS_START,
        DP_INS_SHIFT,
        DP_INS_PUT,
        DP_DEL_START,
        DP_DEL_STEP,
        DP_FIN_INS,
        DP_FIN_FULL,
        DP_FIN_DEL
    } dp_op_t;

    typedef struct packed {
        logic cmd_del;
        logic empty;
        logic full;
        logic greater;
        logic pos_is_one;
        logic rd_last;
    } dp_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS_SCAN,
        S_INS_PUT,
        S_DEL_SCAN,
        S_FIN_INS,
        S_FIN_FULL,
        S_FIN_DEL
    } ctrl_state_t;

endpackage

@@ src/sorted_table_insert_delete.sv @@
// Top level of the sorted table that inserts values and deletes all copies of a value.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+---------------------------------------------
//   s_      | in        | s_tvalid/s_tready  | s_tuser: cmd; s_tdata: value
//   m_      | out       | m_tvalid/m_tready  | m_tdata: status, count, removed
//
// One word is handled at a time. An insert walks down past the k stored entries larger
// than the value, so at most n with n stored entries; a delete walks all n entries. A
// rejected insert or a delete from an empty table does no walk. The entry memory has a
// single read port and a single write port, which let the walk move one entry per
// cycle. Reset empties the table at once, with no clearing pass, since entries are read
// only below the count. A stalled result waits in the output register while the next
// word is accepted; that word's result is then held back until the output is taken.
module sorted_table_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stid_pkg::VALUE_W-1:0]       s_tdata,   // [31:0] value
    input  logic                               s_tuser,   // [0] cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stid_pkg::OUT_TDATA_W-1:0]   m_tdata    // [1:0] status, [6:2] count,
                                                          // [11:7] removed, [15:12] zero
);
    import stid_pkg::*;

    dp_op_t              op;
    dp_status_t          status;
    logic [STATUS_W-1:0] res_status;
    logic [FIELD_W-1:0]  res_count;
    logic [FIELD_W-1:0]  res_removed;

    // The controller owns the handshakes and issues one datapath command per cycle.
    stid_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .op        (op)
    );

    // The datapath holds the entries, the count and the registered result fields.
    stid_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .in_cmd      (s_tuser),
        .in_value    ($signed(s_tdata)),
        .status      (status),
        .res_status  (res_status),
        .res_count   (res_count),
        .res_removed (res_removed)
    );

    // Fields are packed from the lowest bit up and padded with zeros to two bytes.
    assign m_tdata = {{(OUT_TDATA_W - STATUS_W - 2 * FIELD_W){1'b0}},
                      res_removed, res_count, res_status};

endmodule

@@ src/stid_datapath.sv @@
// Datapath of the sorted table: entry memory, pointers, count and result register.
module stid_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  stid_pkg::dp_op_t                      op,
    input  logic                                  in_cmd,
    input  logic signed [stid_pkg::VALUE_W-1:0]   in_value,
    output stid_pkg::dp_status_t                  status,
    output logic [stid_pkg::STATUS_W-1:0]         res_status,
    output logic [stid_pkg::FIELD_W-1:0]          res_count,
    output logic [stid_pkg::FIELD_W-1:0]          res_removed
);
    import stid_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] mem [CAPACITY];

    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [CW-1:0]             ptr_reg, ptr_next;
    logic [CW-1:0]             wptr_reg, wptr_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic                      cmd_reg, cmd_next;
    logic [VALUE_W-1:0]        rd_data_reg;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [FIELD_W-1:0]  res_count_reg, res_count_next;
    logic [FIELD_W-1:0]  res_removed_reg, res_removed_next;
    logic                res_load;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] ptr_m1;
    logic [CW-1:0] ptr_m2;
    logic [CW-1:0] cnt_p1;
    logic [CW-1:0] gone;

    assign cnt_m1 = cnt_reg - CW'(1);
    assign cnt_p1 = cnt_reg + CW'(1);
    assign ptr_m1 = ptr_reg - CW'(1);
    assign ptr_m2 = ptr_reg - CW'(2);
    assign gone   = cnt_reg - wptr_reg;

    assign status.cmd_del    = (cmd_reg == CMD_DELETE);
    assign status.empty      = (cnt_reg == '0);
    assign status.full       = (cnt_reg == CW'(CAPACITY));
    assign status.greater    = ($signed(rd_data_reg) > key_reg);
    assign status.pos_is_one = (ptr_reg == CW'(1));
    assign status.rd_last    = (ptr_reg == cnt_reg);

    always_comb
    begin
        cnt_next         = cnt_reg;
        ptr_next         = ptr_reg;
        wptr_next        = wptr_reg;
        key_next         = key_reg;
        cmd_next         = cmd_reg;
        wr_en            = 1'b0;
        wr_addr          = ptr_reg[AW-1:0];
        wr_data          = rd_data_reg;
        rd_en            = 1'b0;
        rd_addr          = ptr_reg[AW-1:0];
        res_load         = 1'b0;
        res_status_next  = ST_OK;
        res_count_next   = FIELD_W'(cnt_reg);
        res_removed_next = '0;
        unique case (op)
            DP_NOP:
            begin
            end
            DP_LOAD:
            begin
                key_next = in_value;
                cmd_next = in_cmd;
            end
            DP_INS_START:
            begin
                ptr_next = cnt_reg;
                rd_en    = !status.empty;
                rd_addr  = cnt_m1[AW-1:0];
            end
            DP_INS_SHIFT:
            begin
                // The entry below is larger: move it up one place.
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[AW-1:0];
                wr_data  = rd_data_reg;
                ptr_next = ptr_m1;
                rd_en    = !status.pos_is_one;
                rd_addr  = ptr_m2[AW-1:0];
            end
            DP_INS_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg[AW-1:0];
                wr_data = key_reg;
            end
            DP_DEL_START:
            begin
                ptr_next  = CW'(1);
                wptr_next = '0;
                rd_en     = 1'b1;
                rd_addr   = '0;
            end
            DP_DEL_STEP:
            begin
                // Keep entries that differ from the key, packed toward zero.
                if ($signed(rd_data_reg) != key_reg)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = wptr_reg[AW-1:0];
                    wr_data   = rd_data_reg;
                    wptr_next = wptr_reg + CW'(1);
                end
                if (!status.rd_last)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg[AW-1:0];
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            DP_FIN_INS:
            begin
                cnt_next        = cnt_p1;
                res_load        = 1'b1;
                res_status_next = ST_OK;
                res_count_next  = FIELD_W'(cnt_p1);
            end
            DP_FIN_FULL:
            begin
                res_load        = 1'b1;
                res_status_next = ST_FULL;
                res_count_next  = FIELD_W'(cnt_reg);
            end
            DP_FIN_DEL:
            begin
                cnt_next         = wptr_reg;
                res_load         = 1'b1;
                res_status_next  = (gone == '0) ? ST_NOT_FOUND : ST_OK;
                res_count_next   = FIELD_W'(wptr_reg);
                res_removed_next = FIELD_W'(gone);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ptr_reg  <= '0;
            wptr_reg <= '0;
            cmd_reg  <= CMD_INSERT;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ptr_reg  <= ptr_next;
            wptr_reg <= wptr_next;
            cmd_reg  <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (res_load)
        begin
            res_status_reg  <= res_status_next;
            res_count_reg   <= res_count_next;
            res_removed_reg <= res_removed_next;
        end
    end

    assign res_status  = res_status_reg;
    assign res_count   = res_count_reg;
    assign res_removed = res_removed_reg;

endmodule

@@ src/stid_controller.sv @@
// Controller state machine that sequences each insert or delete and the result handshake.
module stid_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  stid_pkg::dp_status_t status,
    output stid_pkg::dp_op_t     op
);
    import stid_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                priority if (status.cmd_del)
                begin
                    state_next = status.empty ? S_FIN_DEL : S_DEL_SCAN;
                end
                else if (status.full)
                begin
                    state_next = S_FIN_FULL;
                end
                else
                begin
                    state_next = status.empty ? S_INS_PUT : S_INS_SCAN;
                end
            end
            S_INS_SCAN:
            begin
                if (status.greater)
                begin
                    state_next = status.pos_is_one ? S_INS_PUT : S_INS_SCAN;
                end
                else
                begin
                    state_next = S_FIN_INS;
                end
            end
            S_INS_PUT:
            begin
                state_next = S_FIN_INS;
            end
            S_DEL_SCAN:
            begin
                if (status.rd_last)
                begin
                    state_next = S_FIN_DEL;
                end
            end
            S_FIN_INS, S_FIN_FULL, S_FIN_DEL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op             = DP_NOP;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = DP_LOAD;
                end
            end
            S_START:
            begin
                priority if (status.cmd_del)
                begin
                    op = status.empty ? DP_NOP : DP_DEL_START;
                end
                else if (status.full)
                begin
                    op = DP_NOP;
                end
                else
                begin
                    op = DP_INS_START;
                end
            end
            S_INS_SCAN:
            begin
                op = status.greater ? DP_INS_SHIFT : DP_INS_PUT;
            end
            S_INS_PUT:
            begin
                op = DP_INS_PUT;
            end
            S_DEL_SCAN:
            begin
                op = DP_DEL_STEP;
            end
            S_FIN_INS:
            begin
                if (out_free)
                begin
                    op             = DP_FIN_INS;
                    out_valid_next = 1'b1;
                end
            end
            S_FIN_FULL:
            begin
                if (out_free)
                begin
                    op             = DP_FIN_FULL;
                    out_valid_next = 1'b1;
                end
            end
            S_FIN_DEL:
            begin
                if (out_free)
                begin
                    op             = DP_FIN_DEL;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                op = DP_NOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/stid_checker.sv @@
// Port-level assertions for the sorted table, bound to its top level.
module stid_checker #(
    parameter int CAPACITY = 16
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [stid_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import stid_pkg::*;

    // A result never carries the unused status code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_FULL
                      || m_tdata[1:0] == ST_NOT_FOUND))
        else $error("result status code out of range");

    // A failed command never reports removed copies.
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[11:7] == '0))
        else $error("removed count on a failed command");

    // The reported count never exceeds the table size.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (CAPACITY > 31 || 32'(m_tdata[6:2]) <= CAPACITY))
        else $error("reported count above capacity");

    // Words are handled one at a time, so the input is not ready in the cycle after an acceptance.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind sorted_table_insert_delete stid_checker #(.CAPACITY(CAPACITY)) u_stid_checker (.*);
